>>> hdl/assert_macros.svh
// assertion macros used by the checker file srq_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define CHK_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("srq check failed");

// invariant checked at every rising edge outside reset
`define CHK_ALWAYS(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("srq check failed");

`endif

>>> hdl/srq_pkg.sv
// types, constants and helpers for the sorted request queue
// no dependencies
package srq_pkg;

    localparam int QUEUE_DEPTH  = 32;
    localparam int SECTOR_SHIFT = 9;
    localparam int ADDR_W       = $clog2(QUEUE_DEPTH);
    localparam int TOTAL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int TAG_W    = 8;
    localparam int SECTOR_W = 32;
    localparam int COUNT_W  = 20;
    localparam int BYTES_W  = 24;

    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_MODE = 1'b0;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_MERGE  = 2'd1,
        OP_PEEK   = 2'd2,
        OP_TAKE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MERGED   = 3'd1,
        ST_NO_MATCH = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    typedef struct packed {
        op_t                 op;
        logic                insert_front;
        logic [TAG_W-1:0]    request_tag;
        logic [SECTOR_W-1:0] start_sector;
        logic [COUNT_W-1:0]  sector_count;
        logic [BYTES_W-1:0]  transfer_bytes;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        logic [TAG_W-1:0]    head_tag;
        logic [SECTOR_W-1:0] head_sector;
        logic [COUNT_W-1:0]  head_count;
    } out_item_t;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [SECTOR_W-1:0] sector;
        logic [COUNT_W-1:0]  count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic               key_lt;
        logic               end_hit;
        logic               overflow;
        logic [COUNT_W-1:0] new_count;
    } cmp_res_t;

    // physical slot of a logical position, ring of QUEUE_DEPTH slots
    function automatic logic [ADDR_W-1:0] slot_addr(
        input logic [ADDR_W-1:0]  base,
        input logic [TOTAL_W-1:0] ofs
    );
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + (ADDR_W + 1)'(ofs);
        if (sum >= (ADDR_W + 1)'(QUEUE_DEPTH))
        begin
            sum = sum - (ADDR_W + 1)'(QUEUE_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

>>> hdl/sorted_request_queue_with_merge.sv
// sorted request queue with merge: sequencer, config register, queue ring
// depends on srq_pkg, srq_ram, srq_cmp
//
//  channel  | signals                                  | beat taken when
//  ---------+------------------------------------------+------------------------------
//  command  | start, busy, cmd                         | start && !busy
//  result   | done, result                             | done (held one cycle)
//  config   | psel penable pwrite paddr pwdata prdata  | psel && penable && pwrite
//
// peek, take and insert into a full queue use S_HEAD, insert to front S_FRONT, insert
// at tail S_APPEND; sorted insert scans every entry and merge scans up to the first
// entry ending at its start sector, one entry a cycle from the single read port of the
// queue ram; peek, take and merge on an empty queue finish in idle without raising busy
// rst_n clears the entry count, ring head and mode; queue contents are left as they are
// results are strobed by done for one cycle and cannot be stalled
module sorted_request_queue_with_merge (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [srq_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  srq_pkg::in_item_t            cmd,
    output logic                         done,
    output srq_pkg::out_item_t           result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_FRONT,
        S_APPEND,
        S_SCAN,
        S_SHIFT_END,
        S_MERGE
    } state_t;

    state_t                          state_reg, state_next;
    srq_pkg::in_item_t               item_reg, item_next;
    logic                            mode_reg, mode_next;
    logic [srq_pkg::ADDR_W-1:0]      head_reg, head_next;
    logic [srq_pkg::TOTAL_W-1:0]     total_reg, total_next;
    logic [srq_pkg::TOTAL_W-1:0]     idx_reg, idx_next;
    logic                            found_reg, found_next;
    srq_pkg::entry_t                 carry_reg, carry_next;
    srq_pkg::out_item_t              res_reg, res_next;
    logic                            done_reg, done_next;

    logic                            ram_we;
    logic [srq_pkg::ADDR_W-1:0]      ram_waddr;
    logic [srq_pkg::ADDR_W-1:0]      ram_raddr;
    srq_pkg::entry_t                 ram_wdata;
    logic [srq_pkg::ENTRY_W-1:0]     ram_rdata;
    srq_pkg::entry_t                 rd_ent;
    srq_pkg::entry_t                 new_ent;
    srq_pkg::entry_t                 upd_ent;
    srq_pkg::cmp_res_t               cmp;
    logic [srq_pkg::TOTAL_W-1:0]     idx_inc;
    logic [srq_pkg::TOTAL_W-1:0]     last_idx;
    logic [srq_pkg::ADDR_W-1:0]      head_dec;
    logic                            cfg_wr;

    srq_ram #(
        .WIDTH (srq_pkg::ENTRY_W),
        .DEPTH (srq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    srq_cmp u_cmp (
        .ent        (rd_ent),
        .key_sector (item_reg.start_sector),
        .xfer_bytes (item_reg.transfer_bytes),
        .res        (cmp)
    );

    assign rd_ent   = srq_pkg::entry_t'(ram_rdata);
    assign idx_inc  = idx_reg + srq_pkg::TOTAL_W'(1);
    assign last_idx = total_reg - srq_pkg::TOTAL_W'(1);
    assign head_dec = (head_reg == '0) ? srq_pkg::ADDR_W'(srq_pkg::QUEUE_DEPTH - 1)
                                       : head_reg - srq_pkg::ADDR_W'(1);

    assign new_ent.tag    = item_reg.request_tag;
    assign new_ent.sector = item_reg.start_sector;
    assign new_ent.count  = item_reg.sector_count;

    assign upd_ent.tag    = rd_ent.tag;
    assign upd_ent.sector = rd_ent.sector;
    assign upd_ent.count  = cmp.new_count;

    assign cfg_wr = psel && penable && pwrite
                    && (paddr[srq_pkg::PADDR_W-1:2] == srq_pkg::REG_MODE);
    assign pready = 1'b1;
    assign prdata = (paddr[srq_pkg::PADDR_W-1:2] == srq_pkg::REG_MODE) ? {31'b0, mode_reg}
                                                                       : 32'b0;

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = res_reg;

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        mode_next  = cfg_wr ? pwdata[0] : mode_reg;
        head_next  = head_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        carry_next = carry_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = head_reg;
        ram_wdata  = new_ent;
        ram_raddr  = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = cmd;
                    idx_next   = '0;
                    found_next = 1'b0;
                    case (cmd.op)
                        srq_pkg::OP_INSERT:
                        begin
                            if (total_reg == srq_pkg::TOTAL_W'(srq_pkg::QUEUE_DEPTH))
                            begin
                                state_next = S_HEAD;
                            end
                            else if (cmd.insert_front)
                            begin
                                state_next = S_FRONT;
                            end
                            else if (mode_reg && total_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_APPEND;
                            end
                        end
                        srq_pkg::OP_MERGE:
                        begin
                            if (total_reg == '0)
                            begin
                                res_next        = '0;
                                res_next.status = srq_pkg::ST_NO_MATCH;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                state_next = S_MERGE;
                            end
                        end
                        srq_pkg::OP_PEEK, srq_pkg::OP_TAKE:
                        begin
                            if (total_reg == '0)
                            begin
                                res_next        = '0;
                                res_next.status = srq_pkg::ST_EMPTY;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                state_next = S_HEAD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_HEAD:
            begin
                res_next.status      = (item_reg.op == srq_pkg::OP_INSERT) ? srq_pkg::ST_FULL
                                                                           : srq_pkg::ST_OK;
                res_next.head_tag    = rd_ent.tag;
                res_next.head_sector = rd_ent.sector;
                res_next.head_count  = rd_ent.count;
                if (item_reg.op == srq_pkg::OP_TAKE)
                begin
                    head_next  = srq_pkg::slot_addr(head_reg, srq_pkg::TOTAL_W'(1));
                    total_next = last_idx;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_FRONT:
            begin
                ram_we               = 1'b1;
                ram_waddr            = head_dec;
                head_next            = head_dec;
                total_next           = total_reg + srq_pkg::TOTAL_W'(1);
                res_next.status      = srq_pkg::ST_OK;
                res_next.head_tag    = new_ent.tag;
                res_next.head_sector = new_ent.sector;
                res_next.head_count  = new_ent.count;
                done_next            = 1'b1;
                state_next           = S_IDLE;
            end

            S_APPEND:
            begin
                ram_we          = 1'b1;
                ram_waddr       = srq_pkg::slot_addr(head_reg, total_reg);
                total_next      = total_reg + srq_pkg::TOTAL_W'(1);
                res_next.status = srq_pkg::ST_OK;
                if (total_reg == '0)
                begin
                    res_next.head_tag    = new_ent.tag;
                    res_next.head_sector = new_ent.sector;
                    res_next.head_count  = new_ent.count;
                end
                else
                begin
                    res_next.head_tag    = rd_ent.tag;
                    res_next.head_sector = rd_ent.sector;
                    res_next.head_count  = rd_ent.count;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_SCAN:
            begin
                // rdata holds entry idx, entry idx + 1 is being read
                ram_raddr = srq_pkg::slot_addr(head_reg, idx_inc);
                ram_waddr = srq_pkg::slot_addr(head_reg, idx_reg);
                if (found_reg)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = carry_reg;
                    carry_next = rd_ent;
                end
                else if (cmp.key_lt)
                begin
                    ram_we     = 1'b1;
                    carry_next = rd_ent;
                    found_next = 1'b1;
                end
                if (idx_reg == '0)
                begin
                    if (cmp.key_lt)
                    begin
                        res_next.head_tag    = new_ent.tag;
                        res_next.head_sector = new_ent.sector;
                        res_next.head_count  = new_ent.count;
                    end
                    else
                    begin
                        res_next.head_tag    = rd_ent.tag;
                        res_next.head_sector = rd_ent.sector;
                        res_next.head_count  = rd_ent.count;
                    end
                end
                idx_next = idx_inc;
                if (idx_reg == last_idx)
                begin
                    state_next = S_SHIFT_END;
                end
            end

            S_SHIFT_END:
            begin
                ram_we          = 1'b1;
                ram_waddr       = srq_pkg::slot_addr(head_reg, total_reg);
                ram_wdata       = found_reg ? carry_reg : new_ent;
                total_next      = total_reg + srq_pkg::TOTAL_W'(1);
                res_next.status = srq_pkg::ST_OK;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end

            S_MERGE:
            begin
                ram_raddr = srq_pkg::slot_addr(head_reg, idx_inc);
                ram_waddr = srq_pkg::slot_addr(head_reg, idx_reg);
                ram_wdata = upd_ent;
                if (cmp.end_hit)
                begin
                    if (cmp.overflow)
                    begin
                        res_next.status      = srq_pkg::ST_OVERFLOW;
                        res_next.head_tag    = rd_ent.tag;
                        res_next.head_sector = rd_ent.sector;
                        res_next.head_count  = rd_ent.count;
                    end
                    else
                    begin
                        ram_we               = 1'b1;
                        res_next.status      = srq_pkg::ST_MERGED;
                        res_next.head_tag    = upd_ent.tag;
                        res_next.head_sector = upd_ent.sector;
                        res_next.head_count  = upd_ent.count;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (idx_reg == last_idx)
                begin
                    res_next        = '0;
                    res_next.status = srq_pkg::ST_NO_MATCH;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            item_reg  <= '0;
            mode_reg  <= 1'b0;
            head_reg  <= '0;
            total_reg <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            carry_reg <= '0;
            res_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            item_reg  <= item_next;
            mode_reg  <= mode_next;
            head_reg  <= head_next;
            total_reg <= total_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            carry_reg <= carry_next;
            res_reg   <= res_next;
            done_reg  <= done_next;
        end
    end

endmodule

>>> hdl/srq_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module srq_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/srq_cmp.sv
// shared compare and add unit used by every queue scan step
// depends on srq_pkg
module srq_cmp (
    input  srq_pkg::entry_t                     ent,
    input  logic [srq_pkg::SECTOR_W-1:0]        key_sector,
    input  logic [srq_pkg::BYTES_W-1:0]         xfer_bytes,
    output srq_pkg::cmp_res_t                   res
);

    logic [srq_pkg::COUNT_W-1:0]  add;
    logic [srq_pkg::SECTOR_W:0]   ent_end;
    logic [srq_pkg::COUNT_W:0]    sum;

    always_comb
    begin
        add     = srq_pkg::COUNT_W'(xfer_bytes >> srq_pkg::SECTOR_SHIFT);
        ent_end = {1'b0, ent.sector} + (srq_pkg::SECTOR_W + 1)'(ent.count);
        sum     = {1'b0, ent.count} + {1'b0, add};

        res.key_lt    = key_sector < ent.sector;
        res.end_hit   = ent_end == {1'b0, key_sector};
        res.overflow  = sum[srq_pkg::COUNT_W];
        res.new_count = sum[srq_pkg::COUNT_W-1:0];
    end

endmodule

>>> hdl/srq_checker.sv
// port level checks for the sorted request queue, bound to the top level
// depends on srq_pkg, assert_macros.svh, sorted_request_queue_with_merge
`include "assert_macros.svh"

module srq_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic [31:0]                  prdata,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input srq_pkg::out_item_t           result
);

    logic no_entry_beat;
    logic entry_fields_zero;

    assign no_entry_beat     = done && (result.status == srq_pkg::ST_EMPTY
                                        || result.status == srq_pkg::ST_NO_MATCH);
    assign entry_fields_zero = result.head_tag == '0 && result.head_sector == '0
                               && result.head_count == '0;

    // a result beat only follows a command or work in progress
    `CHK_IMPLIES(a_done_after_work, clk, rst_n, done, $past(busy || start))

    // leaving the busy phase always delivers a result
    `CHK_IMPLIES(a_busy_ends_with_done, clk, rst_n, $fell(busy), done)

    // empty and no-match results carry no entry
    `CHK_IMPLIES(a_no_entry_fields_zero, clk, rst_n, no_entry_beat, entry_fields_zero)

    // mode register reads back one bit only
    `CHK_ALWAYS(a_prdata_upper_zero, clk, rst_n, prdata[31:1] == '0)

endmodule

bind sorted_request_queue_with_merge srq_checker u_srq_checker (.*);

>>> tb/tb.sv
// testbench for sorted_request_queue_with_merge: directed and random command beats
// checked against a queue scoreboard; depends on srq_pkg and the block itself
import srq_pkg::*;

class queue_scoreboard;
    entry_t      slots[QUEUE_DEPTH];
    int unsigned total;
    logic        sorted_mode;
    out_item_t   pending_results[$];
    int          mismatches;
    int          checked;
    int          status_seen[6];

    function new();
        total       = 0;
        sorted_mode = 1'b0;
        mismatches  = 0;
        checked     = 0;
        foreach (status_seen[i])
        begin
            status_seen[i] = 0;
        end
    endfunction

    function void set_mode(logic m);
        sorted_mode = m;
    endfunction

    function out_item_t entry_result(status_t st, entry_t e);
        out_item_t r;
        r.status      = st;
        r.head_tag    = e.tag;
        r.head_sector = e.sector;
        r.head_count  = e.count;
        return r;
    endfunction

    // advance the queue by one command and queue the result it must produce
    function void note_item(in_item_t c);
        out_item_t            r;
        entry_t               e;
        int unsigned          pos;
        int unsigned          i;
        logic [SECTOR_W:0]    entry_end;
        logic [COUNT_W:0]     grown;
        logic [COUNT_W-1:0]   add;
        bit                   hit;
        r = '0;
        case (c.op)
            OP_INSERT:
            begin
                if (total >= QUEUE_DEPTH)
                begin
                    r = entry_result(ST_FULL, slots[0]);
                end
                else
                begin
                    e.tag    = c.request_tag;
                    e.sector = c.start_sector;
                    e.count  = c.sector_count;
                    pos = total;
                    if (c.insert_front)
                    begin
                        pos = 0;
                    end
                    else if (sorted_mode)
                    begin
                        for (i = 0; i < total; i++)
                        begin
                            if (c.start_sector < slots[i].sector)
                            begin
                                pos = i;
                                break;
                            end
                        end
                    end
                    for (i = total; i > pos; i--)
                    begin
                        slots[i] = slots[i-1];
                    end
                    slots[pos] = e;
                    total++;
                    r = entry_result(ST_OK, slots[0]);
                end
            end
            OP_MERGE:
            begin
                add = COUNT_W'(c.transfer_bytes >> SECTOR_SHIFT);
                r.status = ST_NO_MATCH;
                hit = 1'b0;
                for (i = 0; i < total && !hit; i++)
                begin
                    entry_end = {1'b0, slots[i].sector} + (SECTOR_W + 1)'(slots[i].count);
                    if (entry_end == {1'b0, c.start_sector})
                    begin
                        hit = 1'b1;
                        grown = {1'b0, slots[i].count} + {1'b0, add};
                        if (grown[COUNT_W])
                        begin
                            r = entry_result(ST_OVERFLOW, slots[i]);
                        end
                        else
                        begin
                            slots[i].count = grown[COUNT_W-1:0];
                            r = entry_result(ST_MERGED, slots[i]);
                        end
                    end
                end
            end
            default:
            begin
                if (total == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else if (c.op == OP_PEEK)
                begin
                    r = entry_result(ST_OK, slots[0]);
                end
                else
                begin
                    r = entry_result(ST_OK, slots[0]);
                    for (i = 0; i + 1 < total; i++)
                    begin
                        slots[i] = slots[i+1];
                    end
                    total--;
                end
            end
        endcase
        pending_results.push_back(r);
    endfunction

    task report_mismatch(string what);
        mismatches++;
        if (mismatches <= 30)
        begin
            $display("mismatch %0d: %s", mismatches, what);
        end
    endtask

    task check_result(out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result beat with no command waiting, status %0d",
                                      got.status));
            return;
        end
        want = pending_results.pop_front();
        checked++;
        if (int'(want.status) < 6)
        begin
            status_seen[int'(want.status)]++;
        end
        if (got.status !== want.status)
        begin
            report_mismatch($sformatf("result %0d status got %0d exp %0d",
                                      checked, got.status, want.status));
        end
        if (got.head_tag !== want.head_tag)
        begin
            report_mismatch($sformatf("result %0d head_tag got %0h exp %0h",
                                      checked, got.head_tag, want.head_tag));
        end
        if (got.head_sector !== want.head_sector)
        begin
            report_mismatch($sformatf("result %0d head_sector got %0h exp %0h",
                                      checked, got.head_sector, want.head_sector));
        end
        if (got.head_count !== want.head_count)
        begin
            report_mismatch($sformatf("result %0d head_count got %0h exp %0h",
                                      checked, got.head_count, want.head_count));
        end
    endtask
endclass

module tb;
    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 start;
    logic                 busy;
    in_item_t             cmd;
    logic                 done;
    out_item_t            result;

    queue_scoreboard      sb;
    int                   accepted;
    int                   fill_goal;
    int                   mode_writes;
    in_item_t             directed_q[$];

    sorted_request_queue_with_merge dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        #(12 * 1000000);
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(result);
        end
    end

    function automatic in_item_t mk(op_t op, logic front, logic [TAG_W-1:0] tag,
                                    logic [SECTOR_W-1:0] sector, logic [COUNT_W-1:0] count,
                                    logic [BYTES_W-1:0] bytes);
        in_item_t c;
        c.op             = op;
        c.insert_front   = front;
        c.request_tag    = tag;
        c.start_sector   = sector;
        c.sector_count   = count;
        c.transfer_bytes = bytes;
        return c;
    endfunction

    function automatic int idle_gap(int pct);
        int n;
        n = 0;
        while (n < 60 && $urandom_range(99) < pct)
        begin
            n++;
        end
        return n;
    endfunction

    function automatic logic [SECTOR_W-1:0] random_sector();
        logic [SECTOR_W-1:0] s;
        case ($urandom_range(9))
            0, 1, 2, 3: s = $urandom;
            4, 5, 6:    s = $urandom_range(255);
            7:          s = '0;
            8:          s = '1;
            default:    s = 32'hFFFF_FFFF - $urandom_range(20'hFFFFF);
        endcase
        return s;
    endfunction

    // mostly commands that hit live entries, steered toward a moving fill level
    function automatic in_item_t random_command();
        in_item_t    c;
        int          r;
        int unsigned idx;
        entry_t      e;
        c.op             = op_t'($urandom_range(3));
        c.insert_front   = 1'($urandom_range(1));
        c.request_tag    = TAG_W'($urandom);
        c.start_sector   = $urandom;
        c.sector_count   = COUNT_W'($urandom);
        c.transfer_bytes = BYTES_W'($urandom);
        if ($urandom_range(39) == 0)
        begin
            case ($urandom_range(4))
                0:       fill_goal = 0;
                1:       fill_goal = 4;
                2:       fill_goal = 16;
                default: fill_goal = QUEUE_DEPTH;
            endcase
        end
        r = $urandom_range(99);
        if (r < 5)
        begin
            return c;
        end
        r = $urandom_range(99);
        if (sb.total < fill_goal)
        begin
            c.op = (r < 55) ? OP_INSERT : (r < 75) ? OP_MERGE : (r < 85) ? OP_PEEK : OP_TAKE;
        end
        else
        begin
            c.op = (r < 15) ? OP_INSERT : (r < 45) ? OP_MERGE : (r < 60) ? OP_PEEK : OP_TAKE;
        end
        if (c.op == OP_INSERT)
        begin
            c.insert_front = ($urandom_range(5) == 0);
            c.start_sector = random_sector();
            case ($urandom_range(7))
                0, 1, 2: c.sector_count = COUNT_W'($urandom);
                3, 4:    c.sector_count = COUNT_W'($urandom_range(64));
                5:       c.sector_count = '0;
                6:       c.sector_count = '1;
                default: c.sector_count = 20'hFFFFF - COUNT_W'($urandom_range(64));
            endcase
        end
        else if (c.op == OP_MERGE)
        begin
            if (sb.total > 0 && $urandom_range(9) < 7)
            begin
                idx = $urandom_range(sb.total - 1);
                e = sb.slots[idx];
                c.start_sector = e.sector + SECTOR_W'(e.count);
            end
            else
            begin
                c.start_sector = random_sector();
            end
            case ($urandom_range(4))
                0, 1:    c.transfer_bytes = BYTES_W'($urandom);
                2:       c.transfer_bytes = BYTES_W'($urandom_range(2047));
                3:       c.transfer_bytes = '1;
                default: c.transfer_bytes = 24'd511;
            endcase
        end
        return c;
    endfunction

    task automatic drive_command(input in_item_t c, input int idle_pct);
        int gap;
        gap = idle_gap(idle_pct);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
        sb.note_item(c);
        accepted++;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (sb.pending_results.size() > 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(REG_MODE));
        pwdata  <= {31'b0, m};
        @(posedge clk);
        penable <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready)
            begin
                break;
            end
        end
        sb.set_mode(m);
        mode_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready)
            begin
                readback = prdata;
                break;
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (readback[0] !== m)
        begin
            sb.report_mismatch($sformatf("scheduler_mode read %0h exp %0h", readback, m));
        end
    endtask

    initial
    begin
        int phase;
        int n;
        int pct;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        cmd         <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        sb          = new();
        accepted    = 0;
        fill_goal   = 8;
        mode_writes = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(1'b0);

        // fifo mode: empty queue, extremes, wrap of the end sector, merge edges
        directed_q.push_back(mk(OP_PEEK, 0, 0, 0, 0, 0));
        directed_q.push_back(mk(OP_TAKE, 1, 8'hFF, '1, '1, '1));
        directed_q.push_back(mk(OP_MERGE, 0, 0, 0, 0, '1));
        directed_q.push_back(mk(OP_INSERT, 0, 8'hFF, '1, '1, '1));
        directed_q.push_back(mk(OP_INSERT, 0, 8'h00, 0, 0, '1));
        directed_q.push_back(mk(OP_INSERT, 1, 8'h5A, 100, 8, 0));
        directed_q.push_back(mk(OP_MERGE, 0, 0, 32'h000F_FFFE, 0, 24'h200));
        directed_q.push_back(mk(OP_MERGE, 0, 0, 108, 0, '1));
        directed_q.push_back(mk(OP_MERGE, 0, 0, 0, 0, 24'd511));
        directed_q.push_back(mk(OP_INSERT, 0, 8'h01, 5000, 20'hFFFF0, 0));
        directed_q.push_back(mk(OP_MERGE, 0, 0, 5000 + 32'hFFFF0, 0, 24'h4000));
        directed_q.push_back(mk(OP_MERGE, 0, 0, 5000 + 32'hFFFF0, 0, 24'd7680));
        directed_q.push_back(mk(OP_PEEK, 0, 0, 0, 0, 0));
        directed_q.push_back(mk(OP_TAKE, 0, 0, 0, 0, 0));
        foreach (directed_q[i])
        begin
            drive_command(directed_q[i], 26);
        end
        wait_drained();
        write_mode(1'b1);

        // sorted mode: ties, extremes, front insert, merge onto first match
        directed_q.delete();
        directed_q.push_back(mk(OP_INSERT, 0, 8'h10, 300, 4, 0));
        directed_q.push_back(mk(OP_INSERT, 0, 8'h11, 100, 2, 0));
        directed_q.push_back(mk(OP_INSERT, 0, 8'h12, 300, 4, 0));
        directed_q.push_back(mk(OP_INSERT, 0, 8'h13, '1, 1, 0));
        directed_q.push_back(mk(OP_INSERT, 0, 8'h14, 0, 3, 0));
        directed_q.push_back(mk(OP_INSERT, 1, 8'h15, 50, 1, 0));
        directed_q.push_back(mk(OP_MERGE, 0, 0, 304, 0, 24'd1024));
        directed_q.push_back(mk(OP_TAKE, 0, 0, 0, 0, 0));
        directed_q.push_back(mk(OP_PEEK, 0, 0, 0, 0, 0));
        foreach (directed_q[i])
        begin
            drive_command(directed_q[i], 0);
        end

        for (phase = 0; phase < 6; phase++)
        begin
            wait_drained();
            write_mode((phase % 2) == 0);
            pct = (phase < 2) ? 26 : (phase < 4) ? 88 : 0;
            for (n = 0; n < 75; n++)
            begin
                drive_command(random_command(), pct);
                if ($urandom_range(59) == 0)
                begin
                    wait_drained();
                end
            end
        end
        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.pending_results.size() > 0)
        begin
            sb.report_mismatch($sformatf("%0d expected results never arrived",
                                         sb.pending_results.size()));
        end

        $display("covered %0d commands over %0d mode writes, %0d results checked",
                 accepted, mode_writes, sb.checked);
        $display("ok %0d, merged %0d, no match %0d, empty %0d, full %0d, overflow %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.status_seen[4], sb.status_seen[5]);
        if (sb.mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+hdl
hdl/srq_pkg.sv
hdl/srq_ram.sv
hdl/srq_cmp.sv
hdl/sorted_request_queue_with_merge.sv
hdl/srq_checker.sv
tb/tb.sv
